### rtl/core/assert_macros.svh
// assertion macros shared by the shuttle irrigator sequencer rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, masked while reset is held
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle check that also runs during reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/sis_pkg.sv
// shared types, codes and segment tables of the shuttle irrigator sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package sis_pkg;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_LOCATE    = 4'd1,
        PH_HOME_SEQ  = 4'd2,
        PH_FWD_START = 4'd3,
        PH_FWD       = 4'd4,
        PH_CHOOSE    = 4'd5,
        PH_RET_FAST  = 4'd6,
        PH_RET_WET   = 4'd7,
        PH_DONE      = 4'd8,
        PH_STOP_HOLD = 4'd9,
        PH_HOMING    = 4'd10
    } t_phase;

    // display messages
    typedef enum logic [1:0] {
        MSG_ZEROS = 2'd0,
        MSG_ON    = 2'd1,
        MSG_OFF   = 2'd2,
        MSG_FC    = 2'd3
    } t_msg;

    // drive bits: bit0 run, bit1 forward, bit2 fast, bit3 water
    localparam logic [3:0] DRV_STOP          = 4'h0;
    localparam logic [3:0] DRV_BACK_FAST_DRY = 4'h5;
    localparam logic [3:0] DRV_FWD_SLOW_WET  = 4'hB;
    localparam logic [3:0] DRV_BACK_SLOW_WET = 4'h9;

    localparam int unsigned HOLD_W = 16;
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 16'd5000;

    // segment patterns, bit0 segment a
    localparam logic [7:0] SEG_ZERO = 8'b0011_1111;
    localparam logic [7:0] SEG_F    = 8'b0111_0001;
    localparam logic [7:0] SEG_N    = 8'b0101_0100;
    localparam logic [7:0] SEG_C    = 8'b0101_1000;

    // one sampled input request
    typedef struct packed {
        logic home_limit_n;
        logic end_limit_n;
        logic start_button_n;
        logic return_wet;
        logic stop_button_n;
        logic stop_edge;
    } t_item;

    // one result request
    typedef struct packed {
        logic       motor_on;
        logic       motor_forward;
        logic       motor_fast;
        logic       water_on;
        logic [7:0] left_segments;
        logic [7:0] right_segments;
        logic [3:0] phase_now;
    } t_result;

    function automatic logic [7:0] left_seg(input t_msg msg);
        logic [7:0] pat;
        unique case (msg)
            MSG_FC:  pat = SEG_F;
            default: pat = SEG_ZERO;
        endcase
        return pat;
    endfunction

    function automatic logic [7:0] right_seg(input t_msg msg);
        logic [7:0] pat;
        unique case (msg)
            MSG_ZEROS: pat = SEG_ZERO;
            MSG_ON:    pat = SEG_N;
            MSG_OFF:   pat = SEG_F;
            MSG_FC:    pat = SEG_C;
            default:   pat = SEG_ZERO;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

### rtl/core/shuttle_irrigator_sequencer.sv
// Shuttle irrigator carriage sequencer. Each accepted request is one tick of
// sampled switch inputs and yields exactly one result request holding the
// motor run/direction/speed, water relay, two seven-segment patterns and the
// phase after the tick. A request passes through the input register and then
// the result register; the step logic is a single pass between them and a
// new request is taken every cycle while the result side keeps up. A waiting
// result only stalls the input when both registers are full. The stop hold
// length is written via i_cfg_we and i_cfg_data; the user must write it only
// while the block is idle, which it does not enforce; it resets to 5000 ticks.
// depends on sis_pkg, sis_in_stage, sis_seq and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module shuttle_irrigator_sequencer
    import sis_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [HOLD_W-1:0] i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_home_limit_n,
    input  wire logic              i_end_limit_n,
    input  wire logic              i_start_button_n,
    input  wire logic              i_return_wet,
    input  wire logic              i_stop_button_n,
    input  wire logic              i_stop_edge,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_motor_on,
    output logic                   o_motor_forward,
    output logic                   o_motor_fast,
    output logic                   o_water_on,
    output logic [7:0]             o_left_segments,
    output logic [7:0]             o_right_segments,
    output logic [3:0]             o_phase_now
);

    logic [HOLD_W-1:0] r_hold_ticks;
    logic              r_out_vld;
    t_result           r_out;

    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_vld;
    logic    w_adv;
    t_result w_result;

    // pack the input fields
    always_comb begin
        w_in_item.home_limit_n   = i_home_limit_n;
        w_in_item.end_limit_n    = i_end_limit_n;
        w_in_item.start_button_n = i_start_button_n;
        w_in_item.return_wet     = i_return_wet;
        w_in_item.stop_button_n  = i_stop_button_n;
        w_in_item.stop_edge      = i_stop_edge;
    end

    // step when a request is held and the result slot is free or draining
    assign w_adv = w_item_vld && (!r_out_vld || i_out_ready);

    // stop hold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HOLD_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_hold_ticks <= i_cfg_data;
        end
    end

    sis_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (w_in_item),
        .i_adv      (w_adv),
        .o_vld      (w_item_vld),
        .o_item     (w_item)
    );

    sis_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_item       (w_item),
        .i_hold_ticks (r_hold_ticks),
        .o_result     (w_result)
    );

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_motor_on       = r_out.motor_on;
    assign o_motor_forward  = r_out.motor_forward;
    assign o_motor_fast     = r_out.motor_fast;
    assign o_water_on       = r_out.water_on;
    assign o_left_segments  = r_out.left_segments;
    assign o_right_segments = r_out.right_segments;
    assign o_phase_now      = r_out.phase_now;

    // input only stalls behind a full, blocked result register
    `ASSERT_IMPL(a_stall_cause, !o_in_ready, o_out_valid && !i_out_ready)
    // a stopped motor leaves direction, speed and water off
    `ASSERT_IMPL(a_stop_clean, o_out_valid && !o_motor_on,
                 !o_motor_forward && !o_motor_fast && !o_water_on)
    // during stop hold the motor is off and the display reads OFF
    `ASSERT_IMPL(a_hold_off, o_out_valid && (o_phase_now == PH_STOP_HOLD),
                 !o_motor_on && (o_right_segments == SEG_F))
    // reset empties the result register
    `ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid)

endmodule

`default_nettype wire

### rtl/core/sis_in_stage.sv
// input register of the shuttle irrigator sequencer
// depends on sis_pkg for the request type
`default_nettype none

module sis_in_stage
    import sis_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_item i_item,
    input  wire logic  i_adv,
    output logic       o_vld,
    output t_item      o_item
);

    logic  r_vld;
    t_item r_item;

    // free when empty or being consumed this cycle
    assign o_in_ready = !r_vld || i_adv;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

### rtl/core/sis_seq.sv
// carriage sequencer state and one-tick step logic
// depends on sis_pkg for phases, messages, drive codes and segment tables
`default_nettype none

module sis_seq
    import sis_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire t_item             i_item,
    input  wire logic [HOLD_W-1:0] i_hold_ticks,
    output t_result                o_result
);

    t_phase            r_phase, n_phase;
    logic [HOLD_W-1:0] r_hold,  n_hold;
    logic [3:0]        r_drive, n_drive;
    t_msg              r_msg,   n_msg;

    logic   w_home;
    logic   w_endl;
    logic   w_both;
    logic   w_hold_more;
    t_phase w_base;

    assign w_home      = i_item.home_limit_n;
    assign w_endl      = i_item.end_limit_n;
    assign w_both      = !w_home && !w_endl;
    assign w_hold_more = r_hold > HOLD_W'(1);
    // both limits reached forces the sequence back to idle first
    assign w_base      = w_both ? PH_IDLE : r_phase;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase) inside
            [PH_IDLE:PH_DONE]: begin
                if (i_item.stop_edge) begin
                    n_phase = PH_STOP_HOLD;
                end else begin
                    n_phase = w_base;
                    unique case (w_base)
                        PH_IDLE:      if (!i_item.start_button_n) n_phase = PH_LOCATE;
                        PH_LOCATE:    n_phase = w_home ? PH_HOME_SEQ : PH_FWD_START;
                        PH_HOME_SEQ:  if (!w_home) n_phase = PH_FWD_START;
                        PH_FWD_START: n_phase = PH_FWD;
                        PH_FWD:       if (!w_endl) n_phase = PH_CHOOSE;
                        PH_CHOOSE:    n_phase = i_item.return_wet ? PH_RET_WET : PH_RET_FAST;
                        PH_RET_FAST,
                        PH_RET_WET:   if (!w_home) n_phase = PH_DONE;
                        default:      n_phase = PH_IDLE;
                    endcase
                end
            end
            PH_STOP_HOLD: begin
                if (!w_hold_more) begin
                    n_phase = (!i_item.stop_button_n && w_home) ? PH_HOMING : PH_IDLE;
                end
            end
            PH_HOMING: begin
                if (!w_home) n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // next drive, message and hold count
    always_comb begin
        n_drive = r_drive;
        n_msg   = r_msg;
        n_hold  = r_hold;
        unique case (r_phase) inside
            [PH_IDLE:PH_DONE]: begin
                if (i_item.stop_edge) begin
                    n_drive = DRV_STOP;
                    n_msg   = MSG_OFF;
                    n_hold  = i_hold_ticks;
                end else begin
                    if (w_both) n_drive = DRV_STOP;
                    unique case (w_base)
                        PH_IDLE:      n_msg = i_item.start_button_n ? MSG_ZEROS : MSG_ON;
                        PH_LOCATE:    if (w_home) n_drive = DRV_BACK_FAST_DRY;
                        PH_FWD_START: n_drive = DRV_FWD_SLOW_WET;
                        PH_CHOOSE:    n_drive = i_item.return_wet ? DRV_BACK_SLOW_WET
                                                                  : DRV_BACK_FAST_DRY;
                        PH_RET_FAST,
                        PH_RET_WET:   if (!w_home) n_drive = DRV_STOP;
                        default:      n_drive = n_drive;
                    endcase
                end
            end
            PH_STOP_HOLD: begin
                if (w_hold_more) begin
                    n_hold = r_hold - HOLD_W'(1);
                end else begin
                    n_hold  = '0;
                    n_drive = (!i_item.stop_button_n && w_home) ? DRV_BACK_FAST_DRY
                                                                : DRV_STOP;
                end
            end
            PH_HOMING: n_drive = w_home ? DRV_BACK_FAST_DRY : DRV_STOP;
            default:   n_drive = r_drive;
        endcase
    end

    // state registers, stepped once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hold  <= '0;
            r_drive <= DRV_STOP;
            r_msg   <= MSG_ZEROS;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_hold  <= n_hold;
            r_drive <= n_drive;
            r_msg   <= n_msg;
        end
    end

    // result of this tick
    always_comb begin
        o_result.motor_on       = n_drive[0];
        o_result.motor_forward  = n_drive[1];
        o_result.motor_fast     = n_drive[2];
        o_result.water_on       = n_drive[3];
        o_result.left_segments  = left_seg(n_msg);
        o_result.right_segments = right_seg(n_msg);
        o_result.phase_now      = n_phase;
    end

endmodule

`default_nettype wire

### tb/shuttle_irrigator_sequencer_tb.sv
// self-checking testbench of the shuttle irrigator carriage sequencer
// predicts every result from its own copy of the sequencer state and compares field by field
// depends on sis_pkg and shuttle_irrigator_sequencer
`timescale 1ns / 100ps

module shuttle_irrigator_sequencer_tb
    import sis_pkg::*;
();

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // configuration port
    logic              cfg_we   = 1'b0;
    logic [HOLD_W-1:0] cfg_data = '0;

    // input and result handshakes
    logic    in_valid  = 1'b0;
    logic    out_ready = 1'b0;
    t_item   cur_tick  = '0;
    logic    o_in_ready;
    logic    o_out_valid;
    t_result seen;

    // request queues
    t_item   pending_ticks[$];
    t_result expected_results[$];

    // predicted sequencer state
    t_phase            sq_phase  = PH_IDLE;
    logic [HOLD_W-1:0] hold_left = '0;
    logic [3:0]        drive     = DRV_STOP;
    t_msg              msg       = MSG_ZEROS;
    logic [HOLD_W-1:0] cfg_hold  = HOLD_TICKS_RESET;

    // bookkeeping
    int unsigned       mismatches     = 0;
    int unsigned       results_checked = 0;
    int unsigned       ticks_queued   = 0;
    int unsigned       stop_holds     = 0;
    int unsigned       settings_used  = 1;
    logic [HOLD_W-1:0] hold_setting   = HOLD_TICKS_RESET;
    logic [15:0]       phases_seen    = '0;

    // sender burst control
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall control
    int unsigned stall_cycle    = 0;
    int unsigned stall_mode     = 0;
    int unsigned holdoff_left   = 0;
    int unsigned holdoffs_done  = 0;

    shuttle_irrigator_sequencer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_home_limit_n  (cur_tick.home_limit_n),
        .i_end_limit_n   (cur_tick.end_limit_n),
        .i_start_button_n(cur_tick.start_button_n),
        .i_return_wet    (cur_tick.return_wet),
        .i_stop_button_n (cur_tick.stop_button_n),
        .i_stop_edge     (cur_tick.stop_edge),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_motor_on      (seen.motor_on),
        .o_motor_forward (seen.motor_forward),
        .o_motor_fast    (seen.motor_fast),
        .o_water_on      (seen.water_on),
        .o_left_segments (seen.left_segments),
        .o_right_segments(seen.right_segments),
        .o_phase_now     (seen.phase_now)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // one tick of the carriage sequencer, updates the predicted state
    function automatic t_result step_sequencer(input t_item it);
        t_result r;
        if (sq_phase == PH_STOP_HOLD) begin
            if (hold_left > 1) begin
                hold_left = hold_left - 1'b1;
            end else begin
                hold_left = '0;
                drive     = DRV_STOP;
                sq_phase  = PH_IDLE;
                if (!it.stop_button_n && it.home_limit_n) begin
                    drive    = DRV_BACK_FAST_DRY;
                    sq_phase = PH_HOMING;
                end
            end
        end else if (sq_phase == PH_HOMING) begin
            if (!it.home_limit_n) begin
                drive    = DRV_STOP;
                sq_phase = PH_IDLE;
            end else begin
                drive = DRV_BACK_FAST_DRY;
            end
        end else if (it.stop_edge) begin
            drive     = DRV_STOP;
            msg       = MSG_OFF;
            hold_left = cfg_hold;
            sq_phase  = PH_STOP_HOLD;
        end else begin
            // both limits at once: stop and fall back to idle
            if (!it.home_limit_n && !it.end_limit_n) begin
                msg      = MSG_FC;
                drive    = DRV_STOP;
                sq_phase = PH_IDLE;
            end
            case (sq_phase)
                PH_IDLE: begin
                    msg = MSG_ZEROS;
                    if (!it.start_button_n) begin
                        msg      = MSG_ON;
                        sq_phase = PH_LOCATE;
                    end
                end
                PH_LOCATE: begin
                    if (it.home_limit_n) begin
                        drive    = DRV_BACK_FAST_DRY;
                        sq_phase = PH_HOME_SEQ;
                    end else begin
                        sq_phase = PH_FWD_START;
                    end
                end
                PH_HOME_SEQ: begin
                    if (!it.home_limit_n) sq_phase = PH_FWD_START;
                end
                PH_FWD_START: begin
                    drive    = DRV_FWD_SLOW_WET;
                    sq_phase = PH_FWD;
                end
                PH_FWD: begin
                    if (!it.end_limit_n) sq_phase = PH_CHOOSE;
                end
                PH_CHOOSE: begin
                    if (it.return_wet) begin
                        drive    = DRV_BACK_SLOW_WET;
                        sq_phase = PH_RET_WET;
                    end else begin
                        drive    = DRV_BACK_FAST_DRY;
                        sq_phase = PH_RET_FAST;
                    end
                end
                PH_RET_FAST, PH_RET_WET: begin
                    if (!it.home_limit_n) begin
                        drive    = DRV_STOP;
                        sq_phase = PH_DONE;
                    end
                end
                default: sq_phase = PH_IDLE;
            endcase
        end

        r.motor_on      = drive[0];
        r.motor_forward = drive[1];
        r.motor_fast    = drive[2];
        r.water_on      = drive[3];
        r.left_segments = (msg == MSG_FC) ? SEG_F : SEG_ZERO;
        case (msg)
            MSG_ON:  r.right_segments = SEG_N;
            MSG_OFF: r.right_segments = SEG_F;
            MSG_FC:  r.right_segments = SEG_C;
            default: r.right_segments = SEG_ZERO;
        endcase
        r.phase_now = sq_phase;
        return r;
    endfunction

    // driver: bursts of requests with random gaps, prediction at acceptance
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (cfg_we) cfg_hold = cfg_data;
            if (in_valid && o_in_ready)
                expected_results.push_back(step_sequencer(cur_tick));
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    cur_tick <= pending_ticks.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
                        gap_left   = $urandom_range(0, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // monitor: compare accepted results, stall on a pattern of its own
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no expectation waiting");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("motor_on", want.motor_on, seen.motor_on);
                check_field("motor_forward", want.motor_forward, seen.motor_forward);
                check_field("motor_fast", want.motor_fast, seen.motor_fast);
                check_field("water_on", want.water_on, seen.water_on);
                check_field("left_segments", want.left_segments, seen.left_segments);
                check_field("right_segments", want.right_segments, seen.right_segments);
                check_field("phase_now", want.phase_now, seen.phase_now);
                phases_seen[seen.phase_now] = 1'b1;
                results_checked++;
            end
        end

        // long hold-off twice so the block fills and stalls its input
        stall_cycle++;
        if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
        if (holdoff_left > 0) begin
            holdoff_left--;
            out_ready <= 1'b0;
        end else if (holdoffs_done < 2 && results_checked >= 600 * (holdoffs_done + 1)) begin
            holdoffs_done++;
            holdoff_left = 250;
            out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= ($urandom_range(0, 9) < 3);
                default: out_ready <= stall_cycle[1];
            endcase
        end
    end

    function automatic t_item switches(input logic home, input logic endl, input logic start,
                                       input logic wet, input logic stopb, input logic edg);
        t_item it;
        it.home_limit_n   = home;
        it.end_limit_n    = endl;
        it.start_button_n = start;
        it.return_wet     = wet;
        it.stop_button_n  = stopb;
        it.stop_edge      = edg;
        return it;
    endfunction

    function automatic t_item any_switches();
        return t_item'(6'($urandom));
    endfunction

    task automatic queue_tick(input t_item it);
        pending_ticks.push_back(it);
        ticks_queued++;
    endtask

    // well-formed carriage move, now and then replaced by noise
    task automatic push_ride(input logic home, input logic endl, input logic start,
                             input logic wet);
        if ($urandom_range(0, 19) == 0)
            queue_tick(any_switches());
        else
            queue_tick(switches(home, endl, start, wet, ($urandom_range(0, 7) != 0), 1'b0));
    endtask

    // one full pass: idle, start, locate home, forward to the end, return home
    task automatic push_walk();
        logic wet;
        wet = 1'($urandom_range(0, 1));
        repeat ($urandom_range(0, 2)) push_ride(1'b1, 1'b1, 1'b1, wet);
        push_ride(1'b1, 1'b1, 1'b0, wet);
        repeat ($urandom_range(0, 3)) push_ride(1'b1, 1'b1, 1'b1, wet);
        push_ride(1'b0, 1'b1, 1'b1, wet);
        push_ride(1'b0, 1'b1, 1'b1, wet);
        repeat ($urandom_range(0, 4)) push_ride(1'b1, 1'b1, 1'b1, wet);
        push_ride(1'b1, 1'b0, 1'b1, wet);
        push_ride(1'b1, 1'b0, 1'b1, wet);
        repeat ($urandom_range(0, 4)) push_ride(1'b1, 1'b1, 1'b1, wet);
        push_ride(1'b0, 1'b1, 1'b1, wet);
        push_ride(1'b0, 1'b1, 1'b1, wet);
    endtask

    // stop edge, hold of the current length, then released (0), held away (1)
    // or held at home (2); edges during hold and homing are random
    task automatic push_stop_hold(input int mode);
        t_item it;
        int unsigned ticks;
        ticks = (hold_setting == 0) ? 1 : 32'(hold_setting);
        stop_holds++;
        it = any_switches();
        it.stop_button_n = 1'b0;
        it.stop_edge     = 1'b1;
        queue_tick(it);
        repeat (ticks - 1) queue_tick(any_switches());
        it = any_switches();
        it.stop_button_n = (mode == 0);
        it.home_limit_n  = (mode != 2);
        queue_tick(it);
        if (mode == 1) begin
            repeat ($urandom_range(0, 3)) begin
                it = any_switches();
                it.home_limit_n = 1'b1;
                queue_tick(it);
            end
            it = any_switches();
            it.home_limit_n = 1'b0;
            queue_tick(it);
        end
    endtask

    // mostly full passes, some stop holds and short noise bursts
    task automatic push_random(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        target = ticks_queued + count;
        while (ticks_queued < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 16) push_walk();
            else if (pick < 18) push_stop_hold($urandom_range(0, 2));
            else repeat ($urandom_range(1, 6)) queue_tick(any_switches());
        end
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_hold(input logic [HOLD_W-1:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        hold_setting = value;
        settings_used++;
    endtask

    // stimulus
    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed pass at the reset hold length
        queue_tick(switches(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));   // idle, no start
        queue_tick(switches(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));   // both limits, start
        queue_tick(switches(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));   // locate, already home
        queue_tick(switches(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));   // forward start
        queue_tick(switches(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));   // forward
        queue_tick(switches(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));   // end reached
        queue_tick(switches(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));   // return slow and wet
        queue_tick(switches(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        queue_tick(switches(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));   // home reached
        queue_tick(switches(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));   // done
        queue_tick(switches(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));   // start away from home
        queue_tick(switches(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));   // locate, drive back
        queue_tick(switches(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        queue_tick(switches(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));   // home reached
        queue_tick(switches(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        queue_tick(switches(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));   // end reached
        queue_tick(switches(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));   // return fast and dry
        queue_tick(switches(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));   // both limits returning
        queue_tick(switches(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));   // start again
        wait_drained();
        write_hold(16'd12);
        push_stop_hold(1);                         // stop held, carriage homes
        wait_drained();

        // shortest holds
        write_hold(16'd1);
        push_stop_hold(0);
        push_stop_hold(2);
        wait_drained();
        write_hold(16'd0);
        push_stop_hold(1);
        push_random(150);
        wait_drained();

        // random phases at short hold lengths
        write_hold(16'd2);
        push_random(350);
        wait_drained();
        write_hold(16'd3);
        push_random(350);
        wait_drained();
        write_hold(HOLD_W'($urandom_range(4, 24)));
        push_random(350);
        wait_drained();
        write_hold(HOLD_W'($urandom_range(1, 24)));
        push_random(350);
        wait_drained();

        // longer hold once
        write_hold(16'd60);
        push_stop_hold(1);
        wait_drained();
        write_hold(16'd3);
        push_random(200);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
        end
        $display("checked %0d results from %0d ticks over %0d hold settings, %0d stop holds",
                 results_checked, ticks_queued, settings_used, stop_holds);
        $display("phases seen mask %b, mismatches %0d", phases_seen[10:0], mismatches);
        if (mismatches == 0)
            $display("PASS shuttle_irrigator_sequencer");
        else
            $display("FAIL shuttle_irrigator_sequencer");
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("timeout with %0d ticks pending", pending_ticks.size());
        $display("FAIL shuttle_irrigator_sequencer");
        $finish;
    end

endmodule
